// ===== rtl/tlrx_pkg.sv =====
package tlrx_pkg;

    // Line store geometry
    localparam int LINE_MAX = 64;
    localparam int LINE_AW  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CNT_W    = 7;
    localparam logic [CNT_W-1:0] LINE_MAX_C = CNT_W'(LINE_MAX);

    // Subnegotiation buffer
    localparam int SUB_DEPTH = 5;
    localparam logic [2:0] SUB_DEPTH_C = 3'(SUB_DEPTH);

    // Telnet byte codes
    localparam logic [7:0] B_IAC   = 8'd255;
    localparam logic [7:0] B_SB    = 8'd250;
    localparam logic [7:0] B_SE    = 8'd240;
    localparam logic [7:0] B_WILL  = 8'd251;
    localparam logic [7:0] B_WONT  = 8'd252;
    localparam logic [7:0] B_DO    = 8'd253;
    localparam logic [7:0] B_DEL   = 8'd127;
    localparam logic [7:0] B_CR    = 8'd13;
    localparam logic [7:0] B_SPACE = 8'd32;
    localparam logic [7:0] B_TILDE = 8'd126;

    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_NAWS = 8'd31;

    // Flag bit positions
    localparam int FL_ECHO = 0;
    localparam int FL_SGA  = 1;
    localparam int FL_NAWS = 2;

    // Result kinds
    localparam logic [1:0] EV_EDIT = 2'd0;
    localparam logic [1:0] EV_LINE = 2'd1;
    localparam logic [1:0] EV_SIZE = 2'd2;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_CMD,
        PH_OPT,
        PH_SUB
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_OFF,
        ACT_ON
    } action_t;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_DEL,
        OP_DUMP,
        OP_NAWS
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD,
        BK_OUT
    } bk_state_t;

    // One request from the parser to the line engine, with a snapshot of
    // the negotiated state that its results must report.
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [15:0] width;
        logic [15:0] height;
        logic [2:0]  flags;
    } tlrx_req_t;

endpackage

// ===== rtl/tlrx_ram.sv =====
module tlrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tlrx_front.sv =====
module tlrx_front import tlrx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       q_full,
    output logic       push,
    output tlrx_req_t  push_req
);

    phase_t      phase_reg, phase_next;
    action_t     action_reg, action_next;
    logic [2:0]  sub_count_reg, sub_count_next;
    logic [7:0]  sub_bytes_reg [SUB_DEPTH];
    logic        sub_we;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [2:0]  flags_reg, flags_next;
    logic [2:0]  opt_mask;
    logic        accept;
    op_t         op;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_comb begin
        opt_mask = 3'b000;
        if (s_in_byte == OPT_ECHO) begin
            opt_mask[FL_ECHO] = 1'b1;
        end else if (s_in_byte == OPT_SGA) begin
            opt_mask[FL_SGA] = 1'b1;
        end else if (s_in_byte == OPT_NAWS) begin
            opt_mask[FL_NAWS] = 1'b1;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        action_next    = action_reg;
        sub_count_next = sub_count_reg;
        sub_we         = 1'b0;
        width_next     = width_reg;
        height_next    = height_reg;
        flags_next     = flags_reg;
        push           = 1'b0;
        op             = OP_APPEND;
        if (accept) begin
            case (phase_reg)
                PH_CMD: begin
                    if (s_in_byte == B_SB) begin
                        sub_count_next = '0;
                        phase_next     = PH_SUB;
                    end else begin
                        if (s_in_byte == B_DO || s_in_byte == B_WILL) begin
                            action_next = ACT_ON;
                        end else if (s_in_byte == B_WONT) begin
                            action_next = ACT_OFF;
                        end else begin
                            action_next = ACT_NONE;
                        end
                        phase_next = PH_OPT;
                    end
                end
                PH_OPT: begin
                    if (action_reg == ACT_ON) begin
                        flags_next = flags_reg | opt_mask;
                    end else begin
                        flags_next = flags_reg & ~opt_mask;
                    end
                    phase_next = PH_TEXT;
                end
                PH_SUB: begin
                    if (s_in_byte == B_SE) begin
                        phase_next = PH_TEXT;
                        if (sub_count_reg == SUB_DEPTH_C && sub_bytes_reg[0] == OPT_NAWS) begin
                            width_next  = {sub_bytes_reg[1], sub_bytes_reg[2]};
                            height_next = {sub_bytes_reg[3], sub_bytes_reg[4]};
                            push        = 1'b1;
                            op          = OP_NAWS;
                        end
                    end else if (s_in_byte != B_IAC && sub_count_reg < SUB_DEPTH_C) begin
                        sub_we         = 1'b1;
                        sub_count_next = sub_count_reg + 3'd1;
                    end
                end
                default: begin
                    phase_next = PH_TEXT;
                    if (s_in_byte == B_IAC) begin
                        phase_next = PH_CMD;
                    end else if (s_in_byte >= B_SPACE && s_in_byte <= B_TILDE) begin
                        push = 1'b1;
                        op   = OP_APPEND;
                    end else if (s_in_byte == B_DEL) begin
                        push = 1'b1;
                        op   = OP_DEL;
                    end else if (s_in_byte == B_CR) begin
                        push = 1'b1;
                        op   = OP_DUMP;
                    end
                end
            endcase
        end
        push_req.op     = op;
        push_req.data   = s_in_byte;
        push_req.width  = width_next;
        push_req.height = height_next;
        push_req.flags  = flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TEXT;
            action_reg    <= ACT_NONE;
            sub_count_reg <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            flags_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            action_reg    <= action_next;
            sub_count_reg <= sub_count_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            flags_reg     <= flags_next;
        end
    end

    // Subnegotiation bytes: no reset, only read once written
    always_ff @(posedge aclk) begin
        if (sub_we) begin
            sub_bytes_reg[sub_count_reg] <= s_in_byte;
        end
    end

endmodule

// ===== rtl/tlrx_queue.sv =====
module tlrx_queue import tlrx_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  tlrx_req_t push_req,
    output logic      full,
    output logic      q_valid,
    output tlrx_req_t q_req,
    input  logic      pop
);

    tlrx_req_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_req   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/tlrx_back.sv =====
module tlrx_back import tlrx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  tlrx_req_t        q_req,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_event_kind,
    output logic [7:0]       m_line_byte,
    output logic [CNT_W-1:0] m_line_length,
    output logic             m_last_of_run,
    output logic [15:0]      m_term_width,
    output logic [15:0]      m_term_height,
    output logic             m_echo_on,
    output logic             m_sga_on,
    output logic             m_naws_on,
    output logic             m_overflow
);

    bk_state_t        state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg;
    logic             out_free;
    logic             dump_last;

    logic             ld;
    logic [1:0]       ld_kind;
    logic [7:0]       ld_byte;
    logic [CNT_W-1:0] ld_len;
    logic             ld_last;
    logic             ld_ovf;

    logic             ram_we;
    logic [7:0]       ram_rdata;

    logic [1:0]       kind_reg;
    logic [7:0]       byte_reg;
    logic [CNT_W-1:0] len_reg;
    logic             last_reg;
    logic [15:0]      width_reg;
    logic [15:0]      height_reg;
    logic [2:0]       flags_reg;
    logic             ovf_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign dump_last = (idx_reg + CNT_W'(1)) == count_reg;

    tlrx_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[LINE_AW-1:0]),
        .wdata (q_req.data),
        .raddr (idx_reg[LINE_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_req.op == OP_DUMP && count_reg != '0) begin
                    state_next = BK_RD;
                end
            end
            BK_RD: begin
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (out_free) begin
                    state_next = dump_last ? BK_IDLE : BK_RD;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and handshake
    always_comb begin
        pop        = 1'b0;
        ld         = 1'b0;
        ld_kind    = EV_EDIT;
        ld_byte    = '0;
        ld_len     = count_reg;
        ld_last    = 1'b1;
        ld_ovf     = 1'b0;
        ram_we     = 1'b0;
        count_next = count_reg;
        idx_next   = idx_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    case (q_req.op)
                        OP_APPEND: begin
                            if (out_free) begin
                                ld  = 1'b1;
                                pop = 1'b1;
                                if (count_reg < LINE_MAX_C) begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                    ld_byte    = q_req.data;
                                end else begin
                                    ld_ovf = 1'b1;
                                end
                                ld_len = count_next;
                            end
                        end
                        OP_DEL: begin
                            if (count_reg == '0) begin
                                pop = 1'b1;
                            end else if (out_free) begin
                                ld         = 1'b1;
                                pop        = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                ld_len     = count_next;
                            end
                        end
                        OP_NAWS: begin
                            if (out_free) begin
                                ld      = 1'b1;
                                pop     = 1'b1;
                                ld_kind = EV_SIZE;
                            end
                        end
                        default: begin
                            // line dump; an empty line gives one empty result
                            ld_kind = EV_LINE;
                            ld_len  = '0;
                            if (count_reg == '0) begin
                                if (out_free) begin
                                    ld  = 1'b1;
                                    pop = 1'b1;
                                end
                            end else begin
                                idx_next = '0;
                            end
                        end
                    endcase
                end
            end
            BK_OUT: begin
                ld_kind = EV_LINE;
                ld_byte = ram_rdata;
                ld_len  = '0;
                ld_last = dump_last;
                if (out_free) begin
                    ld = 1'b1;
                    if (dump_last) begin
                        pop        = 1'b1;
                        count_next = '0;
                    end else begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            kind_reg   <= ld_kind;
            byte_reg   <= ld_byte;
            len_reg    <= ld_len;
            last_reg   <= ld_last;
            ovf_reg    <= ld_ovf;
            width_reg  <= q_req.width;
            height_reg <= q_req.height;
            flags_reg  <= q_req.flags;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_kind  = kind_reg;
    assign m_line_byte   = byte_reg;
    assign m_line_length = len_reg;
    assign m_last_of_run = last_reg;
    assign m_term_width  = width_reg;
    assign m_term_height = height_reg;
    assign m_echo_on     = flags_reg[FL_ECHO];
    assign m_sga_on      = flags_reg[FL_SGA];
    assign m_naws_on     = flags_reg[FL_NAWS];
    assign m_overflow    = ovf_reg;

endmodule

// ===== rtl/telnet_rx_option_line_parser_core.sv =====
// Telnet receive parser: takes one received byte per request on s_, and
// gives line-edit, line-ready and window-size results on m_. The parser
// front takes a byte in every cycle in which its two-entry request queue
// has room; option bytes, command bytes and subnegotiation bytes are
// absorbed there with no result. Printable bytes, DEL and a NAWS window
// size each become one request that the line engine turns into one result
// (none for a DEL on an empty line), so in a steady stream of such bytes
// the block runs at one byte per cycle as long as m_ready stays high. A CR
// that releases a line of n stored bytes makes the line engine start the
// dump, then do one line store read and one output load per byte; the
// front keeps taking bytes until the queue fills behind it. Every result
// carries the option flags and window size as they stood when its byte
// was parsed. No clearing pass after reset: the line store is only read
// below the fill count.
module telnet_rx_option_line_parser_core import tlrx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // received byte requests
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    // result requests
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_event_kind,
    output logic [7:0]       m_line_byte,
    output logic [CNT_W-1:0] m_line_length,
    output logic             m_last_of_run,
    output logic [15:0]      m_term_width,
    output logic [15:0]      m_term_height,
    output logic             m_echo_on,
    output logic             m_sga_on,
    output logic             m_naws_on,
    output logic             m_overflow
);

    // front -> queue
    logic      push;
    tlrx_req_t push_req;
    logic      q_full;

    // queue -> line engine
    logic      q_valid;
    tlrx_req_t q_req;
    logic      pop;

    // Telnet command/option/subnegotiation state machine. Classifies each
    // byte and emits at most one request per byte.
    tlrx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .push      (push),
        .push_req  (push_req)
    );

    // Short decoupling queue: lets the parser run ahead during a line dump.
    tlrx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .pop      (pop)
    );

    // Line engine: owns the line store and fill count, drives the
    // registered result output.
    tlrx_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_line_byte   (m_line_byte),
        .m_line_length (m_line_length),
        .m_last_of_run (m_last_of_run),
        .m_term_width  (m_term_width),
        .m_term_height (m_term_height),
        .m_echo_on     (m_echo_on),
        .m_sga_on      (m_sga_on),
        .m_naws_on     (m_naws_on),
        .m_overflow    (m_overflow)
    );

endmodule
